### sv/tsc_pkg.sv
package tsc_pkg;

	// motion state codes, also the result code
	typedef enum logic [2:0] {
		ST_NONE     = 3'd0,
		ST_FLAT     = 3'd1,
		ST_SINGLE   = 3'd2,
		ST_DOUBLE   = 3'd3,
		ST_SEMIFLAT = 3'd4,
		ST_LOFTIE   = 3'd5
	} motion_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_FLAT_ENTER  = 3'd0,
		REG_FLAT_STAY   = 3'd1,
		REG_THROW_ENTER = 3'd2,
		REG_THROW_HOLD  = 3'd3,
		REG_DIFF        = 3'd4,
		REG_SEMIFLAT    = 3'd5,
		REG_LOFTIE      = 3'd6,
		REG_SINGLE      = 3'd7
	} reg_idx_t;

	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned MAG_W   = LEVEL_W + 1;

	localparam logic [LEVEL_W-1:0] FLAT_ENTER_RST  = 16'd80;
	localparam logic [LEVEL_W-1:0] FLAT_STAY_RST   = 16'd200;
	localparam logic [LEVEL_W-1:0] THROW_ENTER_RST = 16'd80;
	localparam logic [LEVEL_W-1:0] THROW_HOLD_RST  = 16'd200;
	localparam logic [LEVEL_W-1:0] DIFF_RST        = 16'd800;
	localparam logic [LEVEL_W-1:0] SEMIFLAT_RST    = 16'd200;
	localparam logic [LEVEL_W-1:0] LOFTIE_RST      = 16'd1200;
	localparam logic [LEVEL_W-1:0] SINGLE_RST      = 16'd2500;

	typedef struct packed {
		logic [LEVEL_W-1:0] flat_enter;
		logic [LEVEL_W-1:0] flat_stay;
		logic [LEVEL_W-1:0] throw_enter;
		logic [LEVEL_W-1:0] throw_hold;
		logic [LEVEL_W-1:0] diff;
		logic [LEVEL_W-1:0] semiflat;
		logic [LEVEL_W-1:0] loftie;
		logic [LEVEL_W-1:0] single;
	} cfg_t;

	// state-independent decisions for one sample
	typedef struct packed {
		logic    below_flat_enter;
		logic    below_flat_stay;
		logic    below_throw_enter;
		logic    below_throw_hold;
		logic    diff_over;
		motion_t throw_kind;
	} flags_t;

endpackage

### sv/throw_state_classifier.sv
// throw state classifier: takes one imu sample per item (raw and linear
// acceleration, three axes each, signed, 0.01 m/s^2 units) and tracks the
// motion state: none, flat, or a throw sorted by the x magnitude into
// semi-flat, loftie, single or double; flat and throw detection both use
// hysteresis. a result item is produced only when the state changes, so
// most samples give no result. one item is accepted per clock while full
// is low: the front end compares the sample against the thresholds in the
// cycle it is pushed and writes the outcome into a small flags queue
// (QUEUE_DEPTH entries plus a registered head); the back end applies the
// state update to one queued entry per cycle unless a change waits on a
// held result, and loads a changed state into the result register, so an
// outcome passes the head register, then the result register. full rises
// only when the consumer holds back results long enough to fill the queue.
// thresholds must be written through cfg_wen/cfg_index/cfg_data only while
// idle (unenforced); all eight indexes are valid and there is no read-back.
module throw_state_classifier #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_wen,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// sample input
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] lin_accel_x,
	input  logic signed [15:0] lin_accel_y,
	input  logic signed [15:0] lin_accel_z,
	// result output
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         motion_state
);

	tsc_pkg::cfg_t    cfg_q;
	tsc_pkg::flags_t  front_flags, q_flags;
	logic             q_empty, q_pop, q_full;
	tsc_pkg::motion_t cur_state;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flat_enter  <= tsc_pkg::FLAT_ENTER_RST;
			cfg_q.flat_stay   <= tsc_pkg::FLAT_STAY_RST;
			cfg_q.throw_enter <= tsc_pkg::THROW_ENTER_RST;
			cfg_q.throw_hold  <= tsc_pkg::THROW_HOLD_RST;
			cfg_q.diff        <= tsc_pkg::DIFF_RST;
			cfg_q.semiflat    <= tsc_pkg::SEMIFLAT_RST;
			cfg_q.loftie      <= tsc_pkg::LOFTIE_RST;
			cfg_q.single      <= tsc_pkg::SINGLE_RST;
		end else if (cfg_wen) begin
			unique case (tsc_pkg::reg_idx_t'(cfg_index))
				tsc_pkg::REG_FLAT_ENTER:  cfg_q.flat_enter  <= cfg_data;
				tsc_pkg::REG_FLAT_STAY:   cfg_q.flat_stay   <= cfg_data;
				tsc_pkg::REG_THROW_ENTER: cfg_q.throw_enter <= cfg_data;
				tsc_pkg::REG_THROW_HOLD:  cfg_q.throw_hold  <= cfg_data;
				tsc_pkg::REG_DIFF:        cfg_q.diff        <= cfg_data;
				tsc_pkg::REG_SEMIFLAT:    cfg_q.semiflat    <= cfg_data;
				tsc_pkg::REG_LOFTIE:      cfg_q.loftie      <= cfg_data;
				tsc_pkg::REG_SINGLE:      cfg_q.single      <= cfg_data;
				default:                  cfg_q             <= cfg_q;
			endcase
		end
	end

	// front end: magnitudes, maxima and threshold compares
	tsc_front u_front (
		.cfg         (cfg_q),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.lin_accel_x (lin_accel_x),
		.lin_accel_y (lin_accel_y),
		.lin_accel_z (lin_accel_z),
		.flags       (front_flags)
	);

	// decoupling queue between front and back
	tsc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !q_full),
		.din    (front_flags),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_flags),
		.empty  (q_empty)
	);

	assign full = q_full;

	// back end: hysteresis state update and result register
	tsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.flags        (q_flags),
		.flags_empty  (q_empty),
		.flags_pop    (q_pop),
		.cur_state    (cur_state),
		.motion_state (motion_state),
		.empty        (empty),
		.pop          (pop)
	);

	// a freshly shown result is the state the back end just moved to
	a_result_is_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(!empty) |-> (motion_state == cur_state))
		else $error("new result differs from tracked state");

	// the queue only fills while its head is held
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_empty)
		else $error("queue full with no head entry");

	// a change is never dropped: the back end stalls while the result is held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop && !q_empty && (q_pop == 1'b1)) |=> !empty)
		else $error("result register lost its item");

endmodule

### sv/tsc_front.sv
module tsc_front (
	input  tsc_pkg::cfg_t             cfg,
	input  logic signed [15:0]        accel_x,
	input  logic signed [15:0]        accel_y,
	input  logic signed [15:0]        accel_z,
	input  logic signed [15:0]        lin_accel_x,
	input  logic signed [15:0]        lin_accel_y,
	input  logic signed [15:0]        lin_accel_z,
	output tsc_pkg::flags_t           flags
);

	function automatic logic [tsc_pkg::MAG_W-1:0] mag(input logic signed [15:0] v);
		logic [tsc_pkg::MAG_W-1:0] ext;
		ext = {v[15], v};
		return v[15] ? (~ext + tsc_pkg::MAG_W'(1)) : ext;
	endfunction

	logic [tsc_pkg::MAG_W-1:0] ax, ay, az, lx, ly, lz;
	logic [tsc_pkg::MAG_W-1:0] yz, all_max, lxy, lin, diff;

	always_comb begin
		ax = mag(accel_x);
		ay = mag(accel_y);
		az = mag(accel_z);
		lx = mag(lin_accel_x);
		ly = mag(lin_accel_y);
		lz = mag(lin_accel_z);
		yz = (ay > az) ? ay : az;
		all_max = (yz > ax) ? yz : ax;
		lxy = (lx > ly) ? lx : ly;
		lin = (lxy > lz) ? lxy : lz;
		diff = (yz >= lin) ? (yz - lin) : (lin - yz);

		flags.below_flat_enter  = all_max < {1'b0, cfg.flat_enter};
		flags.below_flat_stay   = all_max < {1'b0, cfg.flat_stay};
		flags.below_throw_enter = yz < {1'b0, cfg.throw_enter};
		flags.below_throw_hold  = yz < {1'b0, cfg.throw_hold};
		flags.diff_over         = diff > {1'b0, cfg.diff};

		priority if (ax < {1'b0, cfg.semiflat}) begin
			flags.throw_kind = tsc_pkg::ST_SEMIFLAT;
		end else if (ax < {1'b0, cfg.loftie}) begin
			flags.throw_kind = tsc_pkg::ST_LOFTIE;
		end else if (ax < {1'b0, cfg.single}) begin
			flags.throw_kind = tsc_pkg::ST_SINGLE;
		end else begin
			flags.throw_kind = tsc_pkg::ST_DOUBLE;
		end
	end

endmodule

### sv/tsc_fifo.sv
module tsc_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tsc_pkg::flags_t  din,
	output logic             full,
	input  logic             pop,
	output tsc_pkg::flags_t  dout,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tsc_pkg::flags_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             head_valid_q;
	tsc_pkg::flags_t  head_q;

	logic load, take_mem, bypass, mem_wr;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_comb begin
		load     = !head_valid_q || pop;
		take_mem = load && (cnt_q != '0);
		bypass   = load && (cnt_q == '0) && push;
		mem_wr   = push && !bypass;
	end

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = !head_valid_q;
	assign dout  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			cnt_q        <= '0;
			head_valid_q <= 1'b0;
		end else begin
			if (mem_wr) wr_ptr_q <= nxt(wr_ptr_q);
			if (take_mem) rd_ptr_q <= nxt(rd_ptr_q);
			if (mem_wr && !take_mem) cnt_q <= cnt_q + CNT_W'(1);
			else if (take_mem && !mem_wr) cnt_q <= cnt_q - CNT_W'(1);
			if (load) head_valid_q <= take_mem || bypass;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) mem[wr_ptr_q] <= din;
		if (take_mem) head_q <= mem[rd_ptr_q];
		else if (bypass) head_q <= din;
	end

endmodule

### sv/tsc_back.sv
module tsc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tsc_pkg::flags_t   flags,
	input  logic              flags_empty,
	output logic              flags_pop,
	output tsc_pkg::motion_t  cur_state,
	output logic [2:0]        motion_state,
	output logic              empty,
	input  logic              pop
);

	tsc_pkg::motion_t state_q, out_q, nxt_state;
	logic             out_valid_q;
	logic             throwing_now, flat, throwing, change, slot_free;

	always_comb begin
		flat = (state_q == tsc_pkg::ST_FLAT) ? flags.below_flat_stay
		                                     : flags.below_flat_enter;
		throwing_now = (state_q != tsc_pkg::ST_NONE) && (state_q != tsc_pkg::ST_FLAT);
		throwing = throwing_now ? flags.below_throw_hold
		                        : (flags.below_throw_enter && flags.diff_over);
		priority if (flat) begin
			nxt_state = tsc_pkg::ST_FLAT;
		end else if (throwing) begin
			nxt_state = flags.throw_kind;
		end else begin
			nxt_state = tsc_pkg::ST_NONE;
		end
		change    = nxt_state != state_q;
		slot_free = !out_valid_q || pop;
		flags_pop = !flags_empty && (!change || slot_free);
	end

	assign cur_state    = state_q;
	assign motion_state = out_q;
	assign empty        = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsc_pkg::ST_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (flags_pop) state_q <= nxt_state;
			if (flags_pop && change) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flags_pop && change) out_q <= nxt_state;
	end

endmodule

### test/throw_state_monitor.sv
`timescale 1ns / 100ps
module throw_state_monitor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               push,
	input  logic               full,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] lin_accel_x,
	input  logic signed [15:0] lin_accel_y,
	input  logic signed [15:0] lin_accel_z,
	input  logic               empty,
	input  logic               pop,
	input  logic [2:0]         motion_state,
	output int unsigned        mismatches,
	output int unsigned        states_due
);

	tsc_pkg::cfg_t    levels;
	tsc_pkg::motion_t tracked_state;
	tsc_pkg::motion_t next_state;
	tsc_pkg::motion_t due_state;
	tsc_pkg::motion_t due_states[$];

	function automatic logic [tsc_pkg::MAG_W-1:0] axis_mag(input logic [15:0] v);
		return v[15] ? (tsc_pkg::MAG_W'(17'h10000) - tsc_pkg::MAG_W'(v))
		             : tsc_pkg::MAG_W'(v);
	endfunction

	function automatic logic [tsc_pkg::MAG_W-1:0] mag_max(
			input logic [tsc_pkg::MAG_W-1:0] a,
			input logic [tsc_pkg::MAG_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic tsc_pkg::motion_t classify(input tsc_pkg::motion_t cur,
			input tsc_pkg::cfg_t c,
			input logic [15:0] ax_raw, ay_raw, az_raw, lx_raw, ly_raw, lz_raw);
		logic [tsc_pkg::MAG_W-1:0] ax, yz, peak, lin, diff;
		logic [tsc_pkg::LEVEL_W-1:0] flat_lim, throw_lim;
		logic moving, under, throwing;
		ax = axis_mag(ax_raw);
		yz = mag_max(axis_mag(ay_raw), axis_mag(az_raw));
		peak = mag_max(yz, ax);
		lin = mag_max(mag_max(axis_mag(lx_raw), axis_mag(ly_raw)), axis_mag(lz_raw));
		diff = (yz >= lin) ? yz - lin : lin - yz;
		flat_lim = (cur == tsc_pkg::ST_FLAT) ? c.flat_stay : c.flat_enter;
		if (peak < tsc_pkg::MAG_W'(flat_lim))
			return tsc_pkg::ST_FLAT;
		moving = (cur != tsc_pkg::ST_NONE) && (cur != tsc_pkg::ST_FLAT);
		throw_lim = moving ? c.throw_hold : c.throw_enter;
		under = yz < tsc_pkg::MAG_W'(throw_lim);
		throwing = moving ? under : (under && (diff > tsc_pkg::MAG_W'(c.diff)));
		if (!throwing)
			return tsc_pkg::ST_NONE;
		if (ax < tsc_pkg::MAG_W'(c.semiflat))
			return tsc_pkg::ST_SEMIFLAT;
		if (ax < tsc_pkg::MAG_W'(c.loftie))
			return tsc_pkg::ST_LOFTIE;
		if (ax < tsc_pkg::MAG_W'(c.single))
			return tsc_pkg::ST_SINGLE;
		return tsc_pkg::ST_DOUBLE;
	endfunction

	task automatic report(input string what, input logic [2:0] got,
			input tsc_pkg::motion_t want);
		$display("%0t mismatch: %s, motion_state %0d, expected %0d",
			$time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels.flat_enter = tsc_pkg::FLAT_ENTER_RST;
			levels.flat_stay = tsc_pkg::FLAT_STAY_RST;
			levels.throw_enter = tsc_pkg::THROW_ENTER_RST;
			levels.throw_hold = tsc_pkg::THROW_HOLD_RST;
			levels.diff = tsc_pkg::DIFF_RST;
			levels.semiflat = tsc_pkg::SEMIFLAT_RST;
			levels.loftie = tsc_pkg::LOFTIE_RST;
			levels.single = tsc_pkg::SINGLE_RST;
			tracked_state = tsc_pkg::ST_NONE;
			due_states.delete();
			mismatches = 0;
			states_due = 0;
		end else begin
			if (pop && !empty) begin
				if (due_states.size() == 0) begin
					report("result with nothing expected", motion_state, tsc_pkg::ST_NONE);
				end else begin
					due_state = due_states.pop_front();
					if (motion_state !== due_state)
						report("wrong state", motion_state, due_state);
				end
			end
			if (cfg_wen) begin
				case (cfg_index)
					tsc_pkg::REG_FLAT_ENTER:  levels.flat_enter = cfg_data;
					tsc_pkg::REG_FLAT_STAY:   levels.flat_stay = cfg_data;
					tsc_pkg::REG_THROW_ENTER: levels.throw_enter = cfg_data;
					tsc_pkg::REG_THROW_HOLD:  levels.throw_hold = cfg_data;
					tsc_pkg::REG_DIFF:        levels.diff = cfg_data;
					tsc_pkg::REG_SEMIFLAT:    levels.semiflat = cfg_data;
					tsc_pkg::REG_LOFTIE:      levels.loftie = cfg_data;
					default:                  levels.single = cfg_data;
				endcase
			end
			if (push && !full) begin
				next_state = classify(tracked_state, levels, accel_x, accel_y, accel_z,
					lin_accel_x, lin_accel_y, lin_accel_z);
				if (next_state != tracked_state) begin
					due_states.push_back(next_state);
					tracked_state = next_state;
				end
			end
			states_due = due_states.size();
		end
	end

endmodule

### test/throw_state_classifier_tb.sv
`timescale 1ns / 100ps
module throw_state_classifier_tb;

	// watchdog limit on cycles without any accepted item, well above the hold-off
	localparam int unsigned IDLE_LIMIT = 3000;
	localparam int unsigned PHASES = 10;
	localparam int unsigned ITEMS_PER_PHASE = 87;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PRESSURE_ITEMS = 40;
	// pipeline is a short flags queue with a registered head, then the result register
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] lz;
	} sample_t;

	// shapes of random samples
	typedef enum {
		K_FLAT,
		K_THROW,
		K_NONE,
		K_EXTREME,
		K_BITS
	} sample_kind_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wen = 1'b0;
	logic [2:0]         cfg_index = tsc_pkg::REG_FLAT_ENTER;
	logic [15:0]        cfg_data = '0;
	logic               push = 1'b0;
	logic               full;
	logic signed [15:0] accel_x = '0;
	logic signed [15:0] accel_y = '0;
	logic signed [15:0] accel_z = '0;
	logic signed [15:0] lin_accel_x = '0;
	logic signed [15:0] lin_accel_y = '0;
	logic signed [15:0] lin_accel_z = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [2:0]         motion_state;

	int unsigned mismatches;
	int unsigned states_due;
	int unsigned send_gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_len = 0;
	int unsigned quiet_cycles = 0;

	// copy of the programmed levels, only used to aim samples at the thresholds
	logic [15:0] level_copy [8];

	always #1 clk = ~clk;

	throw_state_classifier dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.lin_accel_x (lin_accel_x),
		.lin_accel_y (lin_accel_y),
		.lin_accel_z (lin_accel_z),
		.empty       (empty),
		.pop         (pop),
		.motion_state(motion_state)
	);

	throw_state_monitor mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.lin_accel_x (lin_accel_x),
		.lin_accel_y (lin_accel_y),
		.lin_accel_z (lin_accel_z),
		.empty       (empty),
		.pop         (pop),
		.motion_state(motion_state),
		.mismatches  (mismatches),
		.states_due  (states_due)
	);

	// watchdog: any accepted item on either side restarts the count
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// result side: random stalls, plus a long hold-off when requested
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				hold_left = hold_len;
				hold_len = 0;
			end
			if (hold_left != 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// magnitude to a signed axis value with random sign; 32768 lands on the most negative
	function automatic logic signed [15:0] axis(input int unsigned m);
		logic signed [15:0] v;
		v = 16'(m);
		if ($urandom_range(1))
			v = -v;
		return v;
	endfunction

	// a magnitude on, just beside, or somewhere around a threshold
	function automatic int unsigned near(input int unsigned lv);
		int unsigned r;
		case ($urandom_range(4))
			0:       r = (lv > 0) ? lv - 1 : 0;
			1:       r = lv;
			2:       r = lv + 1;
			3:       r = $urandom_range(lv);
			default: r = $urandom_range(2 * lv + 16);
		endcase
		if (r > 32768)
			r = 32768;
		return r;
	endfunction

	function automatic logic signed [15:0] extreme_axis();
		case ($urandom_range(5))
			0:       return 16'sd0;
			1:       return 16'sd1;
			2:       return -16'sd1;
			3:       return 16'sd32767;
			4:       return -16'sd32767;
			default: return 16'sh8000;
		endcase
	endfunction

	function automatic logic [15:0] wild_level();
		case ($urandom_range(9))
			0:       return 16'd0;
			1:       return 16'hffff;
			2:       return 16'($urandom_range(65535));
			default: return 16'($urandom_range(4000));
		endcase
	endfunction

	function automatic sample_t make_sample(input sample_kind_t kind);
		sample_t s;
		int unsigned top, yz, lin;
		case (kind)
			K_FLAT: begin
				// every raw axis up to a magnitude near one of the flat levels, linear axes up to 3000
				top = near(level_copy[$urandom_range(1) ? tsc_pkg::REG_FLAT_ENTER
				                                        : tsc_pkg::REG_FLAT_STAY]);
				s.ax = axis($urandom_range(top));
				s.ay = axis($urandom_range(top));
				s.az = axis($urandom_range(top));
				case ($urandom_range(2))
					0:       s.ax = axis(top);
					1:       s.ay = axis(top);
					default: s.az = axis(top);
				endcase
				s.lx = axis($urandom_range(3000));
				s.ly = axis($urandom_range(3000));
				s.lz = axis($urandom_range(3000));
			end
			K_THROW: begin
				// y/z near a throw level, linear peak near yz plus the difference level, or at most yz one sample in four
				yz = near(level_copy[$urandom_range(1) ? tsc_pkg::REG_THROW_ENTER
				                                       : tsc_pkg::REG_THROW_HOLD]);
				lin = yz + near(level_copy[tsc_pkg::REG_DIFF]);
				if (lin > 32768)
					lin = 32768;
				if ($urandom_range(3) == 0)
					lin = $urandom_range(yz);
				if ($urandom_range(1)) begin
					s.ay = axis(yz);
					s.az = axis($urandom_range(yz));
				end else begin
					s.az = axis(yz);
					s.ay = axis($urandom_range(yz));
				end
				s.lx = axis($urandom_range(lin));
				s.ly = axis($urandom_range(lin));
				s.lz = axis($urandom_range(lin));
				case ($urandom_range(2))
					0:       s.lx = axis(lin);
					1:       s.ly = axis(lin);
					default: s.lz = axis(lin);
				endcase
				// x aimed at one of the three sorting levels
				s.ax = axis(near(level_copy[3'(int'(tsc_pkg::REG_SEMIFLAT)
					+ $urandom_range(2))]));
			end
			K_NONE: begin
				s.ax = axis($urandom_range(32768));
				s.ay = axis($urandom_range(32768));
				s.az = axis($urandom_range(32768));
				s.lx = axis($urandom_range(32768));
				s.ly = axis($urandom_range(32768));
				s.lz = axis($urandom_range(32768));
			end
			K_EXTREME: begin
				s.ax = extreme_axis();
				s.ay = extreme_axis();
				s.az = extreme_axis();
				s.lx = extreme_axis();
				s.ly = extreme_axis();
				s.lz = extreme_axis();
			end
			default: begin
				s.ax = 16'($urandom);
				s.ay = 16'($urandom);
				s.az = 16'($urandom);
				s.lx = 16'($urandom);
				s.ly = 16'($urandom);
				s.lz = 16'($urandom);
			end
		endcase
		return s;
	endfunction

	function automatic sample_kind_t pick_kind();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30)
			return K_FLAT;
		if (r < 70)
			return K_THROW;
		if (r < 85)
			return K_NONE;
		if (r < 95)
			return K_EXTREME;
		return K_BITS;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_sample(input sample_t s);
		while ($urandom_range(99) < send_gap_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		accel_x <= s.ax;
		accel_y <= s.ay;
		accel_z <= s.az;
		lin_accel_x <= s.lx;
		lin_accel_y <= s.ly;
		lin_accel_z <= s.lz;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	task automatic send_axes(input logic signed [15:0] ax, ay, az, lx, ly, lz);
		sample_t s;
		s.ax = ax;
		s.ay = ay;
		s.az = az;
		s.lx = lx;
		s.ly = ly;
		s.lz = lz;
		send_sample(s);
	endtask

	// block is idle once every result is out and the last no-change items have drained
	task automatic wait_idle();
		push <= 1'b0;
		while (states_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_level(input tsc_pkg::reg_idx_t idx, input logic [15:0] v);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		level_copy[idx] = v;
		@(negedge clk);
	endtask

	task automatic set_levels(input logic [15:0] fe, fs, te, th, df, sf, lf, sg);
		write_level(tsc_pkg::REG_FLAT_ENTER, fe);
		write_level(tsc_pkg::REG_FLAT_STAY, fs);
		write_level(tsc_pkg::REG_THROW_ENTER, te);
		write_level(tsc_pkg::REG_THROW_HOLD, th);
		write_level(tsc_pkg::REG_DIFF, df);
		write_level(tsc_pkg::REG_SEMIFLAT, sf);
		write_level(tsc_pkg::REG_LOFTIE, lf);
		write_level(tsc_pkg::REG_SINGLE, sg);
		cfg_wen <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned sent, fe, te, sf, lf;
		sample_kind_t kind;
		level_copy[tsc_pkg::REG_FLAT_ENTER] = tsc_pkg::FLAT_ENTER_RST;
		level_copy[tsc_pkg::REG_FLAT_STAY] = tsc_pkg::FLAT_STAY_RST;
		level_copy[tsc_pkg::REG_THROW_ENTER] = tsc_pkg::THROW_ENTER_RST;
		level_copy[tsc_pkg::REG_THROW_HOLD] = tsc_pkg::THROW_HOLD_RST;
		level_copy[tsc_pkg::REG_DIFF] = tsc_pkg::DIFF_RST;
		level_copy[tsc_pkg::REG_SEMIFLAT] = tsc_pkg::SEMIFLAT_RST;
		level_copy[tsc_pkg::REG_LOFTIE] = tsc_pkg::LOFTIE_RST;
		level_copy[tsc_pkg::REG_SINGLE] = tsc_pkg::SINGLE_RST;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed walk through the states at reset levels
		send_axes(0, 0, 0, 0, 0, 0);                // enter flat
		send_axes(150, -150, 0, 0, 0, 0);           // flat kept under the stay level
		send_axes(79, -79, 79, 32767, 0, 0);        // still flat
		send_axes(250, 0, 0, 0, 0, 0);              // leave flat, no throw
		send_axes(100, 50, -50, 900, 0, 0);         // throw start, semi-flat
		send_axes(500, -199, 0, 0, 0, 0);           // throw held, loftie
		send_axes(-2000, 150, 0, 0, 0, 0);          // single
		send_axes(2500, 0, 100, 0, 0, 0);           // double, x equal to single level
		send_axes(16'sh8000, 0, 0, 0, 0, 0);        // most negative x, still double
		send_axes(300, 200, 0, 0, 0, 0);            // y at hold level ends the throw
		send_axes(300, 10, 0, 810, 0, 0);           // difference equal to level, no start
		send_axes(300, 10, 0, 0, -811, 0);          // difference just over, loftie
		send_axes(32767, 16'sh8000, 32767, 0, 0, 0);
		send_axes(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_axes(300, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000); // widest difference
		send_axes(32767, 32767, 32767, 32767, 32767, 32767);
		send_axes(79, 79, -79, 0, 0, 0);            // enter flat just under
		send_axes(199, 0, 0, 0, 0, 0);              // stay just under
		send_axes(200, 0, 0, 0, 0, 0);              // stay level reached, leave
		send_axes(80, 0, 0, 0, 0, 0);               // enter level not passed

		// pressure: results held back while changing items keep coming
		wait_idle();
		hold_len = HOLD_CYCLES;
		for (int i = 0; i < PRESSURE_ITEMS; i++) begin
			if ((i % 2) == 0)
				send_axes(0, 0, 0, 0, 0, 0);
			else
				send_axes(5000, 5000, -5000, 0, 0, 0);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: set_levels(tsc_pkg::FLAT_ENTER_RST, tsc_pkg::FLAT_STAY_RST,
					tsc_pkg::THROW_ENTER_RST, tsc_pkg::THROW_HOLD_RST, tsc_pkg::DIFF_RST,
					tsc_pkg::SEMIFLAT_RST, tsc_pkg::LOFTIE_RST, tsc_pkg::SINGLE_RST);
				// nothing ever detected
				1: set_levels('0, '0, '0, '0, '0, '0, '0, '0);
				// everything flat
				2: set_levels(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
					16'hffff, 16'hffff);
				// flat off, throws open, sorting at reset levels
				3: set_levels('0, '0, 16'hffff, 16'hffff, '0, tsc_pkg::SEMIFLAT_RST,
					tsc_pkg::LOFTIE_RST, tsc_pkg::SINGLE_RST);
				// unordered thresholds
				4: set_levels(16'd500, 16'd100, 16'd300, 16'd50, 16'd100, 16'd3000,
					16'd1000, 16'd2000);
				5, 6, 7: begin
					fe = $urandom_range(300, 20);
					te = $urandom_range(400, 20);
					sf = $urandom_range(800, 50);
					lf = sf + $urandom_range(1500);
					set_levels(16'(fe), 16'(fe + $urandom_range(300)), 16'(te),
						16'(te + $urandom_range(400)), 16'($urandom_range(3000)), 16'(sf),
						16'(lf), 16'(lf + $urandom_range(3000)));
				end
				default: set_levels(wild_level(), wild_level(), wild_level(), wild_level(),
					wild_level(), wild_level(), wild_level(), wild_level());
			endcase

			// idling pattern rotates: none, sender gaps, receiver stalls, both light
			case (phase % 4)
				0: begin
					send_gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_gap_pct = 50;
					stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct = 50;
				end
				default: begin
					send_gap_pct = 6;
					stall_pct = 6;
				end
			endcase

			// runs of one sample shape so throws and flats get entered and held
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				kind = pick_kind();
				repeat ($urandom_range(6, 1)) begin
					send_sample(make_sample(kind));
					sent++;
				end
			end
		end

		// drain and give the verdict
		push <= 1'b0;
		stall_pct = 0;
		while (states_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
